>>> sv/ec_point_scalar_multiply_core_assert.svh
// Assertion macros shared by the checker of the scalar multiply core.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef EC_POINT_SCALAR_MULTIPLY_CORE_ASSERT_SVH
`define EC_POINT_SCALAR_MULTIPLY_CORE_ASSERT_SVH

// same-cycle implication
`define ECSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ECSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ecsm_pkg.sv
// Package for the scalar multiply core: widths, codes, command types and
// the command sequence table. No dependencies.
package ecsm_pkg;

	localparam int SCALAR_BITS  = 32;
	localparam int MOD_BITS     = 31;
	localparam int PROD_BITS    = 2 * MOD_BITS;
	localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);
	localparam int CFG_IDX_BITS = 2;
	localparam int PC_BITS      = 5;
	localparam int STATUS_BITS  = 2;

	localparam logic [MOD_BITS-1:0] MODULUS_RST = MOD_BITS'(23);
	localparam logic [MOD_BITS-1:0] COEFF_RST   = '0;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_COEFF   = CFG_IDX_BITS'(1);

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_NOINV = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_MOV, OP_MUL, OP_RED, OP_INV, OP_OUT
	} op_t;

	typedef enum logic [3:0] {
		R_DX, R_DY, R_AX, R_AY, R_K, R_T1, R_T2, R_LAM, R_INV, R_NX,
		R_XIN, R_YIN, R_KIN
	} reg_id_t;

	typedef struct packed {
		logic    valid;
		op_t     op;
		reg_id_t dst;
		reg_id_t a;
		reg_id_t b;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic fail;
	} dp_stat_t;

	typedef struct packed {
		op_t     op;
		reg_id_t dst;
		reg_id_t a;
		reg_id_t b;
	} ucode_t;

	localparam logic [PC_BITS-1:0] PC_RED     = PC_BITS'(0);
	localparam logic [PC_BITS-1:0] PC_RED_END = PC_BITS'(2);
	localparam logic [PC_BITS-1:0] PC_DBL     = PC_BITS'(3);
	localparam logic [PC_BITS-1:0] PC_DBL_END = PC_BITS'(16);
	localparam logic [PC_BITS-1:0] PC_ADD     = PC_BITS'(17);
	localparam logic [PC_BITS-1:0] PC_ADD_END = PC_BITS'(27);
	localparam logic [PC_BITS-1:0] PC_SET     = PC_BITS'(28);
	localparam logic [PC_BITS-1:0] PC_SET_END = PC_BITS'(29);
	localparam logic [PC_BITS-1:0] PC_OUT     = PC_BITS'(30);

	// Command sequence: reduce inputs, point doubling, point addition,
	// first accumulator load, result read-out.
	function automatic ucode_t ucode(input logic [PC_BITS-1:0] pc);
		ucode_t u;
		case (pc)
			5'd0:  u = '{OP_RED, R_DX,  R_XIN, R_XIN};
			5'd1:  u = '{OP_RED, R_DY,  R_YIN, R_YIN};
			5'd2:  u = '{OP_RED, R_K,   R_KIN, R_KIN};
			5'd3:  u = '{OP_ADD, R_T1,  R_DY,  R_DY};
			5'd4:  u = '{OP_INV, R_INV, R_T1,  R_T1};
			5'd5:  u = '{OP_MUL, R_T1,  R_DX,  R_DX};
			5'd6:  u = '{OP_ADD, R_T2,  R_T1,  R_T1};
			5'd7:  u = '{OP_ADD, R_T1,  R_T2,  R_T1};
			5'd8:  u = '{OP_SUB, R_T1,  R_T1,  R_K};
			5'd9:  u = '{OP_MUL, R_LAM, R_T1,  R_INV};
			5'd10: u = '{OP_MUL, R_T1,  R_LAM, R_LAM};
			5'd11: u = '{OP_ADD, R_T2,  R_DX,  R_DX};
			5'd12: u = '{OP_SUB, R_NX,  R_T1,  R_T2};
			5'd13: u = '{OP_SUB, R_T1,  R_DX,  R_NX};
			5'd14: u = '{OP_MUL, R_T1,  R_LAM, R_T1};
			5'd15: u = '{OP_SUB, R_DY,  R_T1,  R_DY};
			5'd16: u = '{OP_MOV, R_DX,  R_NX,  R_NX};
			5'd17: u = '{OP_SUB, R_T1,  R_DX,  R_AX};
			5'd18: u = '{OP_INV, R_INV, R_T1,  R_T1};
			5'd19: u = '{OP_SUB, R_T1,  R_DY,  R_AY};
			5'd20: u = '{OP_MUL, R_LAM, R_T1,  R_INV};
			5'd21: u = '{OP_MUL, R_T1,  R_LAM, R_LAM};
			5'd22: u = '{OP_SUB, R_T1,  R_T1,  R_AX};
			5'd23: u = '{OP_SUB, R_NX,  R_T1,  R_DX};
			5'd24: u = '{OP_SUB, R_T1,  R_AX,  R_NX};
			5'd25: u = '{OP_MUL, R_T1,  R_LAM, R_T1};
			5'd26: u = '{OP_SUB, R_AY,  R_T1,  R_AY};
			5'd27: u = '{OP_MOV, R_AX,  R_NX,  R_NX};
			5'd28: u = '{OP_MOV, R_AX,  R_DX,  R_DX};
			5'd29: u = '{OP_MOV, R_AY,  R_DY,  R_DY};
			5'd30: u = '{OP_OUT, R_T1,  R_AX,  R_AY};
			default: u = '{OP_MOV, R_T1, R_T1, R_T1};
		endcase
		return u;
	endfunction

endpackage

>>> sv/ecsm_if.sv
// Channel interfaces of the scalar multiply core: item input, result
// output and register write. Depends on ecsm_pkg.
interface ecsm_in_if;
	logic                            valid;
	logic                            ready;
	logic [ecsm_pkg::SCALAR_BITS-1:0] scalar;
	logic [ecsm_pkg::MOD_BITS-1:0]    point_x;
	logic [ecsm_pkg::MOD_BITS-1:0]    point_y;
	modport source (output valid, scalar, point_x, point_y, input ready);
	modport sink   (input valid, scalar, point_x, point_y, output ready);
endinterface

interface ecsm_out_if;
	logic                             valid;
	logic                             ready;
	logic [ecsm_pkg::MOD_BITS-1:0]    result_x;
	logic [ecsm_pkg::MOD_BITS-1:0]    result_y;
	logic [ecsm_pkg::STATUS_BITS-1:0] status;
	modport source (output valid, result_x, result_y, status, input ready);
	modport sink   (input valid, result_x, result_y, status, output ready);
endinterface

interface ecsm_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ecsm_pkg::CFG_IDX_BITS-1:0] index;
	logic [ecsm_pkg::MOD_BITS-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ecsm_div.sv
// Shared restoring divider, one quotient bit per cycle: long mode for
// reduction of a product, short mode for one Euclid step. Depends on ecsm_pkg.
module ecsm_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           long_mode,
	input  logic [ecsm_pkg::PROD_BITS-1:0] dividend,
	input  logic [ecsm_pkg::MOD_BITS-1:0]  divisor,
	output logic                           done,
	output logic [ecsm_pkg::MOD_BITS-1:0]  quot,
	output logic [ecsm_pkg::MOD_BITS-1:0]  rem
);
	logic                              busy_q;
	logic                              done_q;
	logic [ecsm_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [ecsm_pkg::PROD_BITS-1:0]    num_q;
	logic [ecsm_pkg::MOD_BITS-1:0]     den_q;
	logic [ecsm_pkg::MOD_BITS-1:0]     rem_q;
	logic [ecsm_pkg::MOD_BITS-1:0]     quo_q;
	logic [ecsm_pkg::MOD_BITS:0]       trial;
	logic                              fits;

	assign trial = {rem_q, num_q[ecsm_pkg::PROD_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= long_mode ? ecsm_pkg::DIV_CNT_BITS'(ecsm_pkg::PROD_BITS)
				                    : ecsm_pkg::DIV_CNT_BITS'(ecsm_pkg::MOD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ecsm_pkg::DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			// short mode: left-align the narrow dividend
			num_q <= long_mode ? dividend
			                   : {dividend[ecsm_pkg::MOD_BITS-1:0], {ecsm_pkg::MOD_BITS{1'b0}}};
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? ecsm_pkg::MOD_BITS'(trial - {1'b0, den_q})
			              : trial[ecsm_pkg::MOD_BITS-1:0];
			quo_q <= {quo_q[ecsm_pkg::MOD_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule

>>> sv/ecsm_datapath.sv
// Field datapath: register file, modular add/subtract, multiplier,
// extended Euclid inverse, shared divider. Depends on ecsm_pkg, ecsm_div.
module ecsm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ecsm_pkg::MOD_BITS-1:0] modulus,
	input  logic                          ld,
	input  logic [ecsm_pkg::MOD_BITS-1:0] ld_x,
	input  logic [ecsm_pkg::MOD_BITS-1:0] ld_y,
	input  logic [ecsm_pkg::MOD_BITS-1:0] ld_k,
	input  ecsm_pkg::dp_cmd_t             cmd,
	output ecsm_pkg::dp_stat_t            stat,
	output logic [ecsm_pkg::MOD_BITS-1:0] res_x,
	output logic [ecsm_pkg::MOD_BITS-1:0] res_y
);
	localparam int W = ecsm_pkg::MOD_BITS;

	typedef enum logic [2:0] {
		D_IDLE, D_EXEC, D_MUL, D_DIV, D_INV_CHK, D_INV_DIV, D_INV_MUL, D_INV_SUB
	} dstate_t;

	dstate_t                        state_q;
	ecsm_pkg::dp_cmd_t              cmd_q;
	logic [W-1:0]                   rf [16];
	logic [W-1:0]                   rda_q, rdb_q;
	logic [W-1:0]                   xin_q, yin_q, kin_q;
	logic [W-1:0]                   opa, opb;
	logic [ecsm_pkg::PROD_BITS-1:0] prod_q;
	logic [W-1:0]                   r0_q, r1_q, q_q;
	logic signed [W:0]              t0_q, t1_q, qt_q;
	logic signed [W:0]              sq;
	logic signed [2*W+1:0]          qt_full;
	logic [W-1:0]                   res_x_q, res_y_q;
	logic                           done_q, fail_q;
	logic                           wr_en;
	logic [W-1:0]                   wr_data;
	logic [W:0]                     sum;
	logic [W-1:0]                   inv_fix;
	logic                           div_start, div_long, div_done;
	logic [ecsm_pkg::PROD_BITS-1:0] div_num;
	logic [W-1:0]                   div_den, div_quot, div_rem;

	always_comb begin
		case (cmd_q.a)
			ecsm_pkg::R_XIN: opa = xin_q;
			ecsm_pkg::R_YIN: opa = yin_q;
			ecsm_pkg::R_KIN: opa = kin_q;
			default:         opa = rda_q;
		endcase
		opb = rdb_q;
	end

	assign sum     = {1'b0, opa} + {1'b0, opb};
	assign sq      = $signed({1'b0, q_q});
	assign qt_full = sq * t1_q;
	assign inv_fix = t0_q[W] ? W'(t0_q + $signed({1'b0, modulus})) : t0_q[W-1:0];

	always_comb begin
		wr_en   = 1'b0;
		wr_data = opa;
		case (state_q)
			D_EXEC: begin
				case (cmd_q.op)
					ecsm_pkg::OP_ADD: begin
						wr_en   = 1'b1;
						wr_data = (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus})
						                                   : sum[W-1:0];
					end
					ecsm_pkg::OP_SUB: begin
						// wrap in W bits, the true result is below the modulus
						wr_en   = 1'b1;
						wr_data = opa - opb + ((opa < opb) ? modulus : '0);
					end
					ecsm_pkg::OP_MOV: begin
						wr_en   = 1'b1;
						wr_data = opa;
					end
					default: wr_en = 1'b0;
				endcase
			end
			D_DIV: begin
				wr_en   = div_done;
				wr_data = div_rem;
			end
			D_INV_CHK: begin
				wr_en   = (r1_q == '0) && (r0_q == W'(1));
				wr_data = inv_fix;
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_long  = 1'b1;
		div_num   = prod_q;
		div_den   = modulus;
		case (state_q)
			D_EXEC: begin
				div_start = cmd_q.op == ecsm_pkg::OP_RED;
				div_num   = {{W{1'b0}}, opa};
			end
			D_MUL: div_start = 1'b1;
			D_INV_CHK: begin
				div_start = r1_q != '0;
				div_long  = 1'b0;
				div_num   = {{W{1'b0}}, r0_q};
				div_den   = r1_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	ecsm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.long_mode (div_long),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (div_done),
		.quot      (div_quot),
		.rem       (div_rem)
	);

	always_ff @(posedge clk) begin
		if (wr_en)
			rf[cmd_q.dst] <= wr_data;
		if (cmd.valid) begin
			rda_q <= rf[cmd.a];
			rdb_q <= rf[cmd.b];
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			xin_q <= ld_x;
			yin_q <= ld_y;
			kin_q <= ld_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cmd_q   <= '0;
			done_q  <= 1'b0;
			fail_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			fail_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (cmd.valid) begin
						cmd_q   <= cmd;
						state_q <= D_EXEC;
					end
				end
				D_EXEC: begin
					case (cmd_q.op)
						ecsm_pkg::OP_RED: state_q <= D_DIV;
						ecsm_pkg::OP_MUL: begin
							prod_q  <= ecsm_pkg::PROD_BITS'(opa) * ecsm_pkg::PROD_BITS'(opb);
							state_q <= D_MUL;
						end
						ecsm_pkg::OP_INV: begin
							r0_q    <= modulus;
							r1_q    <= opa;
							t0_q    <= '0;
							t1_q    <= (W+1)'(1);
							state_q <= D_INV_CHK;
						end
						ecsm_pkg::OP_OUT: begin
							res_x_q <= opa;
							res_y_q <= opb;
							done_q  <= 1'b1;
							state_q <= D_IDLE;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= D_IDLE;
						end
					endcase
				end
				D_MUL: state_q <= D_DIV;
				D_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				D_INV_CHK: begin
					// gcd found once the remainder runs out
					if (r1_q == '0) begin
						done_q  <= 1'b1;
						fail_q  <= r0_q != W'(1);
						state_q <= D_IDLE;
					end else begin
						state_q <= D_INV_DIV;
					end
				end
				D_INV_DIV: begin
					if (div_done) begin
						q_q     <= div_quot;
						r0_q    <= r1_q;
						r1_q    <= div_rem;
						state_q <= D_INV_MUL;
					end
				end
				D_INV_MUL: begin
					qt_q    <= qt_full[W:0];
					state_q <= D_INV_SUB;
				end
				D_INV_SUB: begin
					t0_q    <= t1_q;
					t1_q    <= t0_q - qt_q;
					state_q <= D_INV_CHK;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign stat  = '{done: done_q, fail: fail_q};
	assign res_x = res_x_q;
	assign res_y = res_y_q;
endmodule

>>> sv/ecsm_ctrl.sv
// Controller: walks the scalar bits, issues datapath commands from the
// sequence table and owns the item handshakes. Depends on ecsm_pkg.
module ecsm_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [ecsm_pkg::SCALAR_BITS-1:0] scalar,
	input  logic [ecsm_pkg::MOD_BITS-1:0]    modulus,
	output logic                             ld,
	output ecsm_pkg::dp_cmd_t                cmd,
	input  ecsm_pkg::dp_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ecsm_pkg::status_t                out_status
);
	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_WAIT, S_BIT, S_AFTER, S_FIN
	} state_t;

	state_t                           state_q;
	logic [ecsm_pkg::PC_BITS-1:0]     pc_q;
	logic [ecsm_pkg::SCALAR_BITS-1:0] s_q;
	logic                             have_q;
	logic                             cmd_valid_q;
	logic                             out_valid_q;
	ecsm_pkg::status_t                status_q, out_status_q;
	ecsm_pkg::ucode_t                 uc;

	assign uc       = ecsm_pkg::ucode(pc_q);
	assign in_ready = state_q == S_IDLE;
	assign ld       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pc_q         <= ecsm_pkg::PC_RED;
			s_q          <= '0;
			have_q       <= 1'b0;
			cmd_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			status_q     <= ecsm_pkg::ST_OK;
			out_status_q <= ecsm_pkg::ST_OK;
		end else begin
			cmd_valid_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						s_q    <= scalar;
						have_q <= 1'b0;
						pc_q   <= ecsm_pkg::PC_RED;
						if (scalar == '0) begin
							status_q <= ecsm_pkg::ST_ZERO;
							state_q  <= S_FIN;
						end else if (modulus < ecsm_pkg::MOD_BITS'(2)) begin
							status_q <= ecsm_pkg::ST_NOINV;
							state_q  <= S_FIN;
						end else begin
							status_q <= ecsm_pkg::ST_OK;
							state_q  <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					// hold the read-out until the previous result has gone
					if (uc.op != ecsm_pkg::OP_OUT || !out_valid_q || out_ready) begin
						cmd_valid_q <= 1'b1;
						state_q     <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (stat.done) begin
						if (stat.fail) begin
							status_q <= ecsm_pkg::ST_NOINV;
							state_q  <= S_FIN;
						end else begin
							case (pc_q)
								ecsm_pkg::PC_RED_END, ecsm_pkg::PC_DBL_END: state_q <= S_BIT;
								ecsm_pkg::PC_SET_END: begin
									have_q  <= 1'b1;
									state_q <= S_AFTER;
								end
								ecsm_pkg::PC_ADD_END: state_q <= S_AFTER;
								ecsm_pkg::PC_OUT:     state_q <= S_FIN;
								default: begin
									pc_q    <= pc_q + 1'b1;
									state_q <= S_ISSUE;
								end
							endcase
						end
					end
				end
				S_BIT: begin
					if (s_q[0]) begin
						pc_q    <= have_q ? ecsm_pkg::PC_ADD : ecsm_pkg::PC_SET;
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_AFTER;
					end
				end
				S_AFTER: begin
					// double only while a higher bit remains
					if (s_q[ecsm_pkg::SCALAR_BITS-1:1] == '0) begin
						pc_q <= ecsm_pkg::PC_OUT;
					end else begin
						s_q  <= s_q >> 1;
						pc_q <= ecsm_pkg::PC_DBL;
					end
					state_q <= S_ISSUE;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd        = '{valid: cmd_valid_q, op: uc.op, dst: uc.dst, a: uc.a, b: uc.b};
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
endmodule

>>> sv/ec_point_scalar_multiply_core.sv
// Channel     | dir | payload                          | transfer when
// item_in     | in  | scalar, point_x, point_y         | valid && ready
// item_out    | out | result_x, result_y, status       | valid && ready
// cfg         | in  | index, data (0 modulus, 1 coeff) | valid && ready (always ready)
//
// One item at a time; reduce, multiply and inverse use the shared divider, one bit per cycle;
// add, subtract and move use no divider; each doubling and addition holds one inverse,
// and an inverse runs one division per Euclid step. A scalar with top bit t runs t doublings
// and (set bits - 1) additions.
// Asynchronous reset clears control and configuration; the register file needs no clearing.
// A stalled result is held in the output register while the next item starts.
//
// Top level: configuration registers and channel wiring.
// Depends on ecsm_pkg, ecsm_if, ecsm_ctrl, ecsm_datapath.
module ec_point_scalar_multiply_core (
	input  logic       clk,
	input  logic       arst_n,
	ecsm_in_if.sink    item_in,
	ecsm_out_if.source item_out,
	ecsm_cfg_if.sink   cfg
);
	logic [ecsm_pkg::MOD_BITS-1:0] modulus_q, coeff_q;
	logic [ecsm_pkg::MOD_BITS-1:0] res_x, res_y;
	logic                          ld;
	ecsm_pkg::dp_cmd_t             cmd;
	ecsm_pkg::dp_stat_t            stat;
	ecsm_pkg::status_t             out_status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= ecsm_pkg::MODULUS_RST;
			coeff_q   <= ecsm_pkg::COEFF_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ecsm_pkg::CFG_MODULUS: modulus_q <= cfg.data;
				ecsm_pkg::CFG_COEFF:   coeff_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	ecsm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item_in.valid),
		.in_ready   (item_in.ready),
		.scalar     (item_in.scalar),
		.modulus    (modulus_q),
		.ld         (ld),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (item_out.valid),
		.out_ready  (item_out.ready),
		.out_status (out_status)
	);

	ecsm_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (modulus_q),
		.ld      (ld),
		.ld_x    (item_in.point_x),
		.ld_y    (item_in.point_y),
		.ld_k    (coeff_q),
		.cmd     (cmd),
		.stat    (stat),
		.res_x   (res_x),
		.res_y   (res_y)
	);

	// zero the coordinates on any error status
	assign item_out.result_x = (out_status == ecsm_pkg::ST_OK) ? res_x : '0;
	assign item_out.result_y = (out_status == ecsm_pkg::ST_OK) ? res_y : '0;
	assign item_out.status   = out_status;
endmodule

>>> sv/ecsm_checker.sv
// Port-level checker for the scalar multiply core, bound to the top level.
// Depends on ecsm_pkg and ec_point_scalar_multiply_core_assert.svh.
`include "ec_point_scalar_multiply_core_assert.svh"

module ecsm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [ecsm_pkg::MOD_BITS-1:0]    result_x,
	input logic [ecsm_pkg::MOD_BITS-1:0]    result_y,
	input logic [ecsm_pkg::STATUS_BITS-1:0] status
);
	`ECSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ECSM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(result_x) && $stable(result_y) && $stable(status), "stalled result changed")
	`ECSM_ASSERT_NOW(a_err_zero, out_valid && status != ecsm_pkg::ST_OK, result_x == '0 && result_y == '0, "error result carries coordinates")
	`ECSM_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second item taken while busy")
endmodule

bind ec_point_scalar_multiply_core ecsm_checker u_ecsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item_in.valid),
	.in_ready  (item_in.ready),
	.out_valid (item_out.valid),
	.out_ready (item_out.ready),
	.result_x  (item_out.result_x),
	.result_y  (item_out.result_y),
	.status    (item_out.status)
);
